// ===== sv/dots_pkg.sv =====
package dots_pkg;

  typedef enum logic [3:0] {
    PH_CODE  = 4'b0001,
    PH_LEN   = 4'b0010,
    PH_VALUE = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    ST_SEARCH = 2'd0,
    ST_FOUND  = 2'd1,
    ST_NONE   = 2'd2,
    ST_TRUNC  = 2'd3
  } status_e;

  localparam logic [7:0] CodePad    = 8'd0;
  localparam logic [7:0] CodeEnd    = 8'd255;
  localparam logic [7:0] TargetRst  = 8'd53;

  typedef struct packed {
    logic [7:0] seg_byte;
    logic       seg_last;
  } in_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       value_valid;
    logic       value_last;
    logic       answer_ready;
    logic [1:0] scan_status;
  } out_t;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] bytes_left;
    logic       record_matches;
  } scan_state_t;

endpackage

// ===== sv/dots_if.sv =====
interface dots_in_if import dots_pkg::*; ();
  logic valid;
  logic ready;
  in_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface dots_out_if import dots_pkg::*; ();
  logic valid;
  logic ready;
  out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/dots_step.sv =====
module dots_step import dots_pkg::*; (
  input  scan_state_t state_i,
  input  in_t         item_i,
  input  logic [7:0]  target_i,
  output scan_state_t state_o,
  output out_t        result_o
);

  logic       singular;
  logic       last;
  logic [7:0] b;
  logic [7:0] left_dec;
  status_e    status;

  assign singular = (target_i == CodePad) || (target_i == CodeEnd);
  assign last     = item_i.seg_last;
  assign b        = item_i.seg_byte;
  assign left_dec = state_i.bytes_left - 8'd1;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    status   = ST_SEARCH;
    case (state_i.phase)
      PH_CODE: begin
        if (singular) begin
          if (b == target_i) begin
            status        = ST_FOUND;
            state_o.phase = PH_DONE;
          end else if (last) begin
            status = ST_NONE;
          end
        end else if (b == CodePad) begin
          if (last) status = ST_NONE;
        end else if (b == CodeEnd) begin
          status        = ST_NONE;
          state_o.phase = PH_DONE;
        end else begin
          state_o.record_matches = (b == target_i);
          state_o.phase          = PH_LEN;
          if (last) status = ST_TRUNC;
        end
      end
      PH_LEN: begin
        state_o.bytes_left = b;
        if (b == 8'd0) begin
          if (state_i.record_matches) begin
            status        = ST_FOUND;
            state_o.phase = PH_DONE;
          end else begin
            state_o.phase = PH_CODE;
            if (last) status = ST_NONE;
          end
        end else begin
          state_o.phase = PH_VALUE;
          if (last) status = ST_TRUNC;
        end
      end
      PH_VALUE: begin
        state_o.bytes_left = left_dec;
        if (state_i.record_matches) begin
          result_o.value_byte  = b;
          result_o.value_valid = 1'b1;
          if (left_dec == 8'd0) begin
            result_o.value_last = 1'b1;
            status              = ST_FOUND;
            state_o.phase       = PH_DONE;
          end else if (last) begin
            status = ST_TRUNC;
          end
        end else if (left_dec == 8'd0) begin
          state_o.phase = PH_CODE;
          if (last) status = ST_NONE;
        end else if (last) begin
          status = ST_TRUNC;
        end
      end
      default: begin
      end
    endcase

    // segment end: drop back to reset state
    if (last) begin
      state_o.phase          = PH_CODE;
      state_o.bytes_left     = 8'd0;
      state_o.record_matches = 1'b0;
    end

    result_o.scan_status  = status;
    result_o.answer_ready = (status != ST_SEARCH);
  end

endmodule

// ===== sv/dhcp_option_tlv_scan.sv =====
// channel  dir  handshake      payload
// -------  ---  -------------  ------------------------------------------------
// in_i     in   valid / ready  seg_byte[7:0], seg_last
// out_o    out  valid / ready  value_byte[7:0], value_valid, value_last,
//                              answer_ready, scan_status[1:0]
// cfg      in   cfg_we_i       cfg_wdata_i[7:0] -> target_code
//
// One request in and one result out per cycle unless out_o stalls; each request
// passes the input register, the scan step, then the result register.
// rst_ni clears the scan state, the stage valids and target_code to 53.
// A stall at out_o holds the result register; in_i.ready stays high while
// the input register is empty or moves forward in the same cycle.
module dhcp_option_tlv_scan import dots_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  dots_in_if.sink     in_i,
  dots_out_if.source  out_o
);

  logic        s1_valid_q, s1_valid_d;
  in_t         s1_data_q;
  logic        out_valid_q, out_valid_d;
  out_t        out_data_q;
  logic [7:0]  target_q;
  scan_state_t state_q, state_d;
  out_t        result;
  logic        out_free, s1_fire, in_fire;

  assign out_free = !out_valid_q || out_o.ready;
  assign s1_fire  = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_fire  = in_i.valid && in_i.ready;

  assign s1_valid_d  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_fire ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  dots_step u_step (
    .state_i  (state_q),
    .item_i   (s1_data_q),
    .target_i (target_q),
    .state_o  (state_d),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      target_q    <= TargetRst;
      state_q     <= '{phase: PH_CODE, bytes_left: 8'd0, record_matches: 1'b0};
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) target_q <= cfg_wdata_i;
      if (s1_fire) state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) s1_data_q <= in_i.payload;
    if (s1_fire) out_data_q <= result;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_data_q;

  a_last_is_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.payload.value_last) |->
      (out_o.payload.answer_ready && out_o.payload.value_valid &&
       out_o.payload.scan_status == ST_FOUND))
    else $error("value_last without found answer");

  a_answer_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |->
      (out_o.payload.answer_ready == (out_o.payload.scan_status != ST_SEARCH)))
    else $error("answer_ready disagrees with scan_status");

  a_segment_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_data_q.seg_last) |=>
      (state_q.phase == PH_CODE && state_q.bytes_left == 8'd0 &&
       !state_q.record_matches))
    else $error("scan state not cleared at segment end");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("result lost between stages");

endmodule
